/* src/assert_macros.svh */
// Assertion macros shared by the RTL of this project.
// Clocked on clk and disabled while rst_n is low; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

/* src/aebr_pkg.sv */
// Types and character constants for the Accept-Encoding br token checker.
// No dependencies.
package aebr_pkg;

  // Scanner phase
  typedef enum logic [3:0] {
    PH_SEEK = 4'd0,
    PH_B_OK = 4'd1,
    PH_B_NO = 4'd2,
    PH_BR   = 4'd3,
    PH_SEMI = 4'd4,
    PH_Q    = 4'd5,
    PH_EQ   = 4'd6,
    PH_ZERO = 4'd7,
    PH_DOT  = 4'd8,
    PH_D1   = 4'd9,
    PH_D2   = 4'd10,
    PH_D3   = 4'd11
  } phase_t;

  // Scanner state carried between bytes of one value
  typedef struct packed {
    phase_t phase;
    logic   prev_delim;
    logic   decided;
    logic   verdict;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{phase: PH_SEEK, prev_delim: 1'b1,
                                         decided: 1'b0, verdict: 1'b0};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_Q  = 8'h71;
  localparam logic [7:0] CH_LO_R  = 8'h72;

  localparam int unsigned DATA_W = 8;

endpackage

/* src/accept_encoding_br_token_check.sv */
// Accept-Encoding "br" token checker, top level.
// Depends on aebr_pkg and assert_macros.svh.
//
// Takes a header value one byte per request (tdata = byte, tuser = byte
// present, tlast = end of value) and returns one verdict per value on the
// request that carries tlast: out_tdata[0] = 1 when the token br is accepted
// (case-insensitive, delimited, not followed by q=0). A request is taken
// every cycle unless a last byte waits; the scanner step works on the input
// register, and the verdict is registered as its last byte retires. The output
// register holds a verdict while the next value's bytes keep flowing; only
// a second tlast request waits for a busy output register.
`include "assert_macros.svh"

module accept_encoding_br_token_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [aebr_pkg::DATA_W-1:0] in_tdata,   // [7:0] value_byte
  input  logic                        in_tuser,   // [0] byte_present
  input  logic                        in_tlast,   // last byte of the value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [aebr_pkg::DATA_W-1:0] out_tdata   // [0] accepted, [7:1] zero
);
  import aebr_pkg::*;

  // One scanner step for a single byte
  function automatic scan_state_t consume(scan_state_t st, logic [7:0] c);
    scan_state_t ns;
    logic        seek;
    ns   = st;
    seek = 1'b0;
    if (!st.decided) begin
      case (st.phase)
        PH_B_OK, PH_B_NO: begin
          if (c inside {CH_LO_R, CH_UP_R}) begin
            ns.phase = (st.phase == PH_B_OK) ? PH_BR : PH_SEEK;
          end else begin
            seek = 1'b1;
          end
        end
        PH_BR: begin
          if (c == CH_SPACE) begin
            ns.phase = PH_SEMI;
          end else if (c == CH_SEMI) begin
            ns.phase = PH_Q;
          end else if (c == CH_COMMA) begin
            ns.decided = 1'b1;
            ns.verdict = 1'b1;
          end else begin
            seek = 1'b1;
          end
        end
        PH_SEMI, PH_Q, PH_EQ, PH_ZERO: begin
          // Optional spaces, then the expected character or accept
          if (c != CH_SPACE) begin
            if ((st.phase == PH_SEMI && c == CH_SEMI) ||
                (st.phase == PH_Q    && c == CH_LO_Q) ||
                (st.phase == PH_EQ   && c == CH_EQ)   ||
                (st.phase == PH_ZERO && c == CH_ZERO)) begin
              ns.phase = phase_t'(st.phase + 4'd1);
            end else begin
              ns.decided = 1'b1;
              ns.verdict = 1'b1;
            end
          end
        end
        PH_DOT: begin
          if (c == CH_DOT) begin
            ns.phase = PH_D1;
          end else begin
            ns.decided = 1'b1;
            ns.verdict = 1'b0;
          end
        end
        PH_D1, PH_D2, PH_D3: begin
          if (c inside {[CH_ONE:CH_NINE]}) begin
            ns.decided = 1'b1;
            ns.verdict = 1'b1;
          end else if (c == CH_ZERO && st.phase != PH_D3) begin
            ns.phase = phase_t'(st.phase + 4'd1);
          end else begin
            ns.decided = 1'b1;
            ns.verdict = 1'b0;
          end
        end
        default: seek = 1'b1;
      endcase
      // Token search
      if (seek) begin
        if (c == CH_NUL) begin
          ns.decided = 1'b1;
          ns.verdict = 1'b0;
        end else if (c inside {CH_LO_B, CH_UP_B}) begin
          ns.phase = st.prev_delim ? PH_B_OK : PH_B_NO;
        end else begin
          ns.phase = PH_SEEK;
        end
      end
      ns.prev_delim = (c == CH_COMMA) || (c == CH_SPACE);
    end
    return ns;
  endfunction

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_present_r;
  logic              s1_last_r;
  logic              s1_fire;
  scan_state_t       state_r;
  scan_state_t       state_nxt;
  scan_state_t       st_byte;
  scan_state_t       st_end;
  logic              fin_verdict;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_accepted_r;

  // Stage 1 retires a byte; a last byte needs a free output register
  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r    <= in_tdata;
      s1_present_r <= in_tuser;
      s1_last_r    <= in_tlast;
    end
  end

  // Next state: scan the byte, restart after the end of a value
  always_comb begin
    st_byte = s1_present_r ? consume(state_r, s1_byte_r) : state_r;
    if (!s1_fire) begin
      state_nxt = state_r;
    end else if (s1_last_r) begin
      state_nxt = SCAN_RESET;
    end else begin
      state_nxt = st_byte;
    end
  end

  // Output: end of value right after br accepts, else it acts as a NUL byte
  always_comb begin
    st_end = st_byte;
    if (!st_byte.decided) begin
      if (st_byte.phase == PH_BR) begin
        st_end.decided = 1'b1;
        st_end.verdict = 1'b1;
      end else begin
        st_end = consume(st_byte, CH_NUL);
      end
    end
    fin_verdict   = st_end.decided && st_end.verdict;
    out_valid_nxt = (s1_fire && s1_last_r) || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SCAN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_accepted_r <= fin_verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(DATA_W-1){1'b0}}, out_accepted_r};

  // Checks
  `ASSERT_CLK(a_restart_after_last, s1_fire && s1_last_r |=> state_r == SCAN_RESET)
  `ASSERT_CLK(a_result_from_last, $rose(out_valid_r) |-> $past(s1_fire && s1_last_r))
  `ASSERT_CLK(a_verdict_final, state_r.decided && s1_fire && !s1_last_r |=> state_r.decided && state_r.verdict == $past(state_r.verdict))
  `ASSERT_NEVER(a_no_overwrite, s1_fire && s1_last_r && out_valid_r && !out_tready)

endmodule
